/* hw/rtl/jls_pkg.sv */
// Shared types and constants of the Jacobi linear solver.
`timescale 1ns / 1ps
`default_nettype none
package jls_pkg;

  // Item modes
  localparam logic [1:0] MODE_LOAD_A = 2'd0;
  localparam logic [1:0] MODE_LOAD_B = 2'd1;
  localparam logic [1:0] MODE_SOLVE  = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_SIZE = 2'd0;
  localparam logic [1:0] CFG_TOL  = 2'd1;
  localparam logic [1:0] CFG_MAXIT = 2'd2;

  localparam int unsigned IdxW = 4;
  localparam int unsigned ValW = 32;
  localparam int unsigned ItW  = 10;
  localparam int unsigned OutLim = 16;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load_a;      // write matrix entry from input item
    logic load_b;      // write rhs entry from input item
    logic clr_x;       // zero old and new solution for a new solve
    logic pivot_chk;   // inspect diagonal of row i
    logic row_start;   // set accumulator to b[i]
    logic mac;         // accumulate one product of row i
    logic mac_last;    // last product of row i has been issued
    logic div_start;   // launch the division for row i
    logic sweep_start; // clear the norm for a new sweep
    logic commit;      // copy new solution into old solution
    logic [IdxW-1:0] i;
    logic [IdxW-1:0] j;
  } jls_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic zero_diag; // diagonal seen by pivot check is zero
    logic busy;      // product pipeline, pivot check, divider or row finish still working
    logic within_tol;
  } jls_sts_t;

endpackage
`default_nettype wire

/* hw/rtl/jls_datapath.sv */
// Datapath of the Jacobi solver: stores, multiply-accumulate, divider, norm.
`timescale 1ns / 1ps
`default_nettype none
module jls_datapath import jls_pkg::*; #(
  parameter int unsigned NMax     = 16,
  parameter int unsigned FracBits = 16
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire jls_cmd_t        cmd_i,
  input  wire logic [IdxW-1:0] row_i,
  input  wire logic [IdxW-1:0] col_i,
  input  wire logic [ValW-1:0] value_i,
  input  wire logic [62:0]     tol_i,
  input  wire logic [IdxW-1:0] rd_idx_i,
  output jls_sts_t             sts_o,
  output logic [ValW-1:0]      x_o
);

  localparam int unsigned AW = (NMax > 1) ? $clog2(NMax) : 1;
  localparam int unsigned MW = 2 * AW;
  localparam int unsigned DivSteps = 64;
  localparam logic signed [63:0] ResLim = (64'sd1 <<< (62 - FracBits)) - 64'sd1;

  // Storage
  logic signed [ValW-1:0] a_mem [NMax << AW];
  logic signed [ValW-1:0] b_mem [NMax];
  logic signed [ValW-1:0] xo_q [NMax];
  logic signed [ValW-1:0] xn_q [NMax];

  logic [AW-1:0] i_a, j_a, row_a, col_a, rd_a;
  assign i_a   = AW'(cmd_i.i);
  assign j_a   = AW'(cmd_i.j);
  assign row_a = AW'(row_i);
  assign col_a = AW'(col_i);
  assign rd_a  = AW'(rd_idx_i);

  logic in_rng;
  assign in_rng = ({28'd0, row_i} < NMax) && ({28'd0, col_i} < NMax);

  // Matrix memory: one write port, one registered read port
  logic [MW-1:0] a_waddr, a_raddr;
  logic signed [ValW-1:0] a_rd_q;
  assign a_waddr = {row_a, col_a};
  assign a_raddr = {i_a, (cmd_i.pivot_chk || cmd_i.div_start) ? i_a : j_a};
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_a && in_rng) begin
      a_mem[a_waddr] <= value_i;
    end
    a_rd_q <= a_mem[a_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_b && ({28'd0, row_i} < NMax)) begin
      b_mem[row_a] <= value_i;
    end
  end

  // Pipeline control: stage 1 reads A and x, stage 2 multiplies, stage 3 adds
  logic mac1_q, mac2_q, last1_q, last2_q, last3_q, piv_q, dst_q;
  logic signed [ValW-1:0] x_rd_q;
  logic signed [63:0] prod_q, acc_q;
  logic zdiag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mac1_q <= 1'b0; mac2_q <= 1'b0;
      last1_q <= 1'b0; last2_q <= 1'b0; last3_q <= 1'b0;
      piv_q <= 1'b0; dst_q <= 1'b0; zdiag_q <= 1'b0;
    end else begin
      mac1_q  <= cmd_i.mac;
      mac2_q  <= mac1_q;
      last1_q <= cmd_i.mac_last;
      last2_q <= last1_q;
      last3_q <= last2_q;
      piv_q   <= cmd_i.pivot_chk;
      dst_q   <= cmd_i.div_start;
      if (piv_q) zdiag_q <= (a_rd_q == '0);
    end
  end

  always_ff @(posedge clk_i) begin
    x_rd_q <= xo_q[j_a];
    prod_q <= 64'(a_rd_q) * 64'(x_rd_q);
  end

  // Accumulate residual: acc = b - sum floor(prod >> F)
  always_ff @(posedge clk_i) begin
    if (cmd_i.row_start) begin
      acc_q <= 64'(b_mem[i_a]);
    end else if (mac2_q) begin
      acc_q <= acc_q - (prod_q >>> FracBits);
    end
  end

  // Divider: restoring, one quotient bit per cycle on magnitudes
  logic div_busy_q;
  logic [6:0] div_cnt_q;
  logic [63:0] dvd_q, rem_q;
  logic [31:0] dvs_q;
  logic neg_q;
  logic [64:0] rem_sh;
  logic signed [63:0] sres;
  logic [63:0] num_mag;
  logic div_done_q;

  always_comb begin
    sres = acc_q;
    if (sres > ResLim) sres = ResLim;
    if (sres < -ResLim) sres = -ResLim;
    num_mag = sres[63] ? 64'(-(sres <<< FracBits)) : 64'(sres <<< FracBits);
    rem_sh = {rem_q, dvd_q[63]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_busy_q <= 1'b0;
      div_cnt_q  <= '0;
      div_done_q <= 1'b0;
    end else begin
      div_done_q <= 1'b0;
      if (dst_q) begin
        div_busy_q <= 1'b1;
        div_cnt_q  <= 7'(DivSteps);
      end else if (div_busy_q) begin
        div_cnt_q <= div_cnt_q - 7'd1;
        if (div_cnt_q == 7'd1) begin
          div_busy_q <= 1'b0;
          div_done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (dst_q) begin
      dvd_q <= num_mag;
      rem_q <= '0;
      dvs_q <= a_rd_q[31] ? 32'(-a_rd_q) : a_rd_q;
      neg_q <= sres[63] ^ a_rd_q[31];
    end else if (div_busy_q) begin
      if (rem_sh >= {33'd0, dvs_q}) begin
        rem_q <= 64'(rem_sh - {33'd0, dvs_q});
        dvd_q <= {dvd_q[62:0], 1'b1};
      end else begin
        rem_q <= rem_sh[63:0];
        dvd_q <= {dvd_q[62:0], 1'b0};
      end
    end
  end

  // Finish the row: saturate update, new x and norm
  logic [IdxW-1:0] fin_i_q;
  logic signed [64:0] q_s;
  logic signed [31:0] upd;
  logic signed [32:0] xs;
  logic signed [31:0] xnew;
  logic [63:0] sq_q, norm_q;
  logic fin2_q;
  logic [64:0] nsum;

  always_comb begin
    q_s = neg_q ? -$signed({1'b0, dvd_q}) : $signed({1'b0, dvd_q});
    if (q_s > 65'sd2147483647) upd = 32'sh7FFFFFFF;
    else if (q_s < -65'sd2147483648) upd = 32'sh80000000;
    else upd = q_s[31:0];
    xs = 33'(xo_q[AW'(fin_i_q)]) + 33'(upd);
    if (xs > 33'sd2147483647) xnew = 32'sh7FFFFFFF;
    else if (xs < -33'sd2147483648) xnew = 32'sh80000000;
    else xnew = xs[31:0];
    nsum = {1'b0, norm_q} + {1'b0, sq_q};
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) fin_i_q <= cmd_i.i;
    if (div_done_q) sq_q <= 64'(upd) * 64'(upd);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fin2_q <= 1'b0;
      norm_q <= '0;
    end else begin
      fin2_q <= div_done_q;
      if (cmd_i.sweep_start) norm_q <= '0;
      else if (fin2_q) norm_q <= nsum[64] ? '1 : nsum[63:0];
    end
  end

  // Solution vectors
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NMax; k++) begin
      if (cmd_i.clr_x) begin
        xo_q[k] <= '0;
        xn_q[k] <= '0;
      end else if (cmd_i.commit) begin
        xo_q[k] <= xn_q[k];
      end
    end
    if (div_done_q && !cmd_i.clr_x) xn_q[AW'(fin_i_q)] <= xnew;
  end

  assign x_o = xn_q[rd_a];
  assign sts_o.zero_diag  = zdiag_q;
  assign sts_o.busy = mac1_q | mac2_q | last1_q | last2_q | last3_q | piv_q | dst_q
                    | div_busy_q | div_done_q | fin2_q;
  assign sts_o.within_tol = (norm_q <= {1'b0, tol_i});

endmodule
`default_nettype wire

/* hw/rtl/jls_ctrl.sv */
// Controller of the Jacobi solver: sequences loads, sweeps and result output.
`timescale 1ns / 1ps
`default_nettype none
module jls_ctrl import jls_pkg::*; #(
  parameter int unsigned NMax = 16
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire logic [1:0]      mode_i,
  input  wire logic [4:0]      size_i,
  input  wire logic [ItW-1:0]  maxit_i,
  output jls_cmd_t             cmd_o,
  input  wire jls_sts_t        sts_i,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output logic [IdxW-1:0]      index_o,
  output logic [ItW-1:0]       iterations_o,
  output logic                 converged_o,
  output logic                 zero_pivot_o,
  output logic                 last_o
);

  localparam int unsigned Lim = (NMax < OutLim) ? NMax : OutLim;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_PIV   = 9'b000000010,
    S_PWAIT = 9'b000000100,
    S_ROW   = 9'b000001000,
    S_MAC   = 9'b000010000,
    S_DIV   = 9'b000100000,
    S_WAIT  = 9'b001000000,
    S_CHECK = 9'b010000000,
    S_OUT   = 9'b100000000
  } state_e;

  state_e state_q, state_d;
  logic [IdxW-1:0] i_q, i_d, j_q, j_d, nm1_q, nm1_d;
  logic [ItW-1:0] it_q, it_d;
  logic conv_q, conv_d, zp_q, zp_d;
  logic fire;

  assign in_ready_o = (state_q == S_IDLE);
  assign fire = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    i_d = i_q; j_d = j_q; nm1_d = nm1_q; it_d = it_q;
    conv_d = conv_q; zp_d = zp_q;
    cmd_o = '0;
    cmd_o.i = i_q;
    cmd_o.j = j_q;
    unique case (state_q)
      S_IDLE: begin
        if (fire) begin
          unique case (mode_i)
            MODE_LOAD_A: cmd_o.load_a = 1'b1;
            MODE_LOAD_B: cmd_o.load_b = 1'b1;
            MODE_SOLVE: begin
              cmd_o.clr_x = 1'b1;
              if (size_i == 5'd0) nm1_d = '0;
              else if ({27'd0, size_i} > Lim) nm1_d = IdxW'(Lim - 1);
              else nm1_d = IdxW'(size_i - 5'd1);
              i_d = '0; it_d = '0; conv_d = 1'b0; zp_d = 1'b0;
              state_d = S_PIV;
            end
            default: ;
          endcase
        end
      end
      // Check each diagonal entry for zero
      S_PIV: begin
        cmd_o.pivot_chk = 1'b1;
        state_d = S_PWAIT;
      end
      S_PWAIT: begin
        if (!sts_i.busy) begin
          if (sts_i.zero_diag) begin
            zp_d = 1'b1; i_d = '0; state_d = S_OUT;
          end else if (i_q == nm1_q) begin
            i_d = '0;
            if (maxit_i == '0) state_d = S_OUT;
            else begin
              cmd_o.sweep_start = 1'b1; it_d = it_q + 1'b1; state_d = S_ROW;
            end
          end else begin
            i_d = i_q + 1'b1; state_d = S_PIV;
          end
        end
      end
      S_ROW: begin
        cmd_o.row_start = 1'b1;
        j_d = '0;
        state_d = S_MAC;
      end
      // Stream one product per cycle across the row
      S_MAC: begin
        cmd_o.mac = 1'b1;
        if (j_q == nm1_q) begin
          cmd_o.mac_last = 1'b1; state_d = S_DIV;
        end else j_d = j_q + 1'b1;
      end
      S_DIV: begin
        if (!sts_i.busy) begin
          cmd_o.div_start = 1'b1; state_d = S_WAIT;
        end
      end
      S_WAIT: begin
        if (!sts_i.busy) begin
          if (i_q == nm1_q) state_d = S_CHECK;
          else begin
            i_d = i_q + 1'b1; state_d = S_ROW;
          end
        end
      end
      S_CHECK: begin
        i_d = '0;
        if (sts_i.within_tol) begin
          conv_d = 1'b1; state_d = S_OUT;
        end else if (it_q == maxit_i) begin
          state_d = S_OUT;
        end else begin
          cmd_o.commit = 1'b1; cmd_o.sweep_start = 1'b1;
          it_d = it_q + 1'b1; state_d = S_ROW;
        end
      end
      // Hand out one item per solution entry
      S_OUT: begin
        if (out_ready_i) begin
          if (i_q == nm1_q) state_d = S_IDLE;
          else i_d = i_q + 1'b1;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      i_q <= '0; j_q <= '0; nm1_q <= '0; it_q <= '0;
      conv_q <= 1'b0; zp_q <= 1'b0;
    end else begin
      state_q <= state_d;
      i_q <= i_d; j_q <= j_d; nm1_q <= nm1_d; it_q <= it_d;
      conv_q <= conv_d; zp_q <= zp_d;
    end
  end

  assign out_valid_o  = (state_q == S_OUT);
  assign index_o      = i_q;
  assign iterations_o = it_q;
  assign converged_o  = conv_q;
  assign zero_pivot_o = zp_q;
  assign last_o       = (i_q == nm1_q);

endmodule
`default_nettype wire

/* hw/rtl/jacobi_linear_solver_top.sv */
// Top level of the Jacobi linear solver.
// Loads: one item per cycle, no result.
// Solve: up to n diagonal checks, then per sweep n rows (row start, products,
//   division) and one check, bounded by the 64-step serial divider; then n result
//   items, one a cycle while out_ready_i is high.
// Reset (asynchronous, active low) clears control state and registers to
//   size 16, tolerance 1, limit 1000; stores hold no value until loaded.
`timescale 1ns / 1ps
`default_nettype none
module jacobi_linear_solver_top import jls_pkg::*; #(
  parameter int unsigned N_MAX     = 16,
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [1:0]         cfg_idx_i,
  input  wire logic [62:0]        cfg_data_i,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [1:0]         mode_i,
  input  wire logic [IdxW-1:0]    row_i,
  input  wire logic [IdxW-1:0]    col_i,
  input  wire logic signed [31:0] value_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [IdxW-1:0]         index_o,
  output logic signed [31:0]      x_value_o,
  output logic [ItW-1:0]          iterations_o,
  output logic                    converged_o,
  output logic                    zero_pivot_o,
  output logic                    last_o
);

  logic [4:0]     size_q;
  logic [62:0]    tol_q;
  logic [ItW-1:0] maxit_q;
  jls_cmd_t cmd;
  jls_sts_t sts;
  logic [31:0] x_w;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= 5'd16; tol_q <= 63'd1; maxit_q <= 10'd1000;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SIZE:  size_q  <= cfg_data_i[4:0];
        CFG_TOL:   tol_q   <= cfg_data_i;
        CFG_MAXIT: maxit_q <= cfg_data_i[ItW-1:0];
        default: ;
      endcase
    end
  end

  jls_ctrl #(.NMax(N_MAX)) u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_o,
    .mode_i, .size_i(size_q), .maxit_i(maxit_q),
    .cmd_o(cmd), .sts_i(sts),
    .out_valid_o, .out_ready_i,
    .index_o, .iterations_o, .converged_o, .zero_pivot_o, .last_o
  );

  jls_datapath #(.NMax(N_MAX), .FracBits(FRAC_BITS)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd),
    .row_i, .col_i, .value_i(value_i), .tol_i(tol_q),
    .rd_idx_i(index_o), .sts_o(sts), .x_o(x_w)
  );

  assign x_value_o = x_w;

endmodule
`default_nettype wire
